// ----- src/rnb_pkg.sv -----
package rnb_pkg;

  localparam int MODULUS_BITS = 62;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUARTER_ROOT = 1'd1;

  typedef struct packed {
    logic [MODULUS_BITS-1:0] sample_a;
    logic [MODULUS_BITS-1:0] sample_b;
    logic [MODULUS_BITS-1:0] sample_c;
    logic [MODULUS_BITS-1:0] sample_d;
    logic                    twiddle_mode;
    logic [MODULUS_BITS-1:0] twiddle_one;
    logic [MODULUS_BITS-1:0] twiddle_two;
    logic [MODULUS_BITS-1:0] twiddle_three;
  } in_item_t;

  typedef struct packed {
    logic [MODULUS_BITS-1:0] result_zero;
    logic [MODULUS_BITS-1:0] result_one;
    logic [MODULUS_BITS-1:0] result_two;
    logic [MODULUS_BITS-1:0] result_three;
  } out_item_t;

endpackage

// ----- src/rnb_reduce.sv -----
module rnb_reduce #(
  parameter int W      = 62,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [W-1:0]                m,
  input  logic [LANES-1:0][W-1:0]     in_val,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][W-1:0]     out_val,
  output logic [SIDE_W-1:0]           out_side
);

  // Horner reduction: one input bit per stage, acc = (2*acc + bit) mod m
  logic [W-1:0]                       vld_r, vld_nxt;
  logic [W-1:0][LANES-1:0][W-1:0]     acc_r, acc_nxt;
  logic [W-1:0][LANES-1:0][W-1:0]     rem_r, rem_nxt;
  logic [W-1:0][SIDE_W-1:0]           side_r, side_nxt;

  always_comb begin
    logic [W-1:0] p_acc;
    logic [W-1:0] p_rem;
    logic [W:0]   sum;
    for (int s = 0; s < W; s++) begin
      vld_nxt[s]  = (s == 0) ? in_valid : vld_r[s-1];
      side_nxt[s] = (s == 0) ? in_side : side_r[s-1];
      for (int l = 0; l < LANES; l++) begin
        p_acc = (s == 0) ? '0 : acc_r[s-1][l];
        p_rem = (s == 0) ? in_val[l] : rem_r[s-1][l];
        sum   = {p_acc, p_rem[W-1]};
        acc_nxt[s][l] = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
        rem_nxt[s][l] = {p_rem[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = vld_r[W-1];
  assign out_val   = acc_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

// ----- src/rnb_mulmod.sv -----
module rnb_mulmod #(
  parameter int W      = 62,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [W-1:0]                m,
  input  logic [LANES-1:0][W-1:0]     in_a,
  input  logic [LANES-1:0][W-1:0]     in_b,
  input  logic [SIDE_W-1:0]           in_side,
  output logic                        out_valid,
  output logic [LANES-1:0][W-1:0]     out_prod,
  output logic [SIDE_W-1:0]           out_side
);

  // shift-and-add modular product, multiplier bits MSB first, one per stage
  logic [W-1:0]                       vld_r, vld_nxt;
  logic [W-1:0][LANES-1:0][W-1:0]     r_r, r_nxt;
  logic [W-1:0][LANES-1:0][W-1:0]     a_r, a_nxt;
  logic [W-1:0][LANES-1:0][W-1:0]     b_r, b_nxt;
  logic [W-1:0][SIDE_W-1:0]           side_r, side_nxt;

  always_comb begin
    logic [W-1:0] p_r;
    logic [W-1:0] p_a;
    logic [W-1:0] p_b;
    logic [W+1:0] sum;
    logic [W+1:0] m1;
    logic [W+1:0] m2;
    m1 = {2'b00, m};
    m2 = {1'b0, m, 1'b0};
    for (int s = 0; s < W; s++) begin
      vld_nxt[s]  = (s == 0) ? in_valid : vld_r[s-1];
      side_nxt[s] = (s == 0) ? in_side : side_r[s-1];
      for (int l = 0; l < LANES; l++) begin
        p_r = (s == 0) ? '0 : r_r[s-1][l];
        p_a = (s == 0) ? in_a[l] : a_r[s-1][l];
        p_b = (s == 0) ? in_b[l] : b_r[s-1][l];
        // 2r + a < 3m, so at most two subtractions of m
        sum = {1'b0, p_r, 1'b0} + {2'b00, (p_b[W-1] ? p_a : {W{1'b0}})};
        if (sum >= m2) begin
          r_nxt[s][l] = W'(sum - m2);
        end else if (sum >= m1) begin
          r_nxt[s][l] = W'(sum - m1);
        end else begin
          r_nxt[s][l] = sum[W-1:0];
        end
        a_nxt[s][l] = p_a;
        b_nxt[s][l] = {p_b[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r    <= r_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = vld_r[W-1];
  assign out_prod  = r_r[W-1];
  assign out_side  = side_r[W-1];

endmodule

// ----- src/radix4_ntt_butterfly.sv -----
// Radix-4 NTT butterfly modulo a programmable modulus (register 0) with the
// quarter root in register 1. Accepts one transaction per clock while the
// output is not stalled and returns one result per transaction, in order,
// through three bit-serial stage chains of one modulus bit per stage:
// operand reduction, the quarter-root product and the twiddle products. A
// stalled output freezes the whole pipeline. Inputs at or above the modulus
// are reduced first; a modulus below two yields all-zero results.
// Program the registers only while no transactions are in flight.
module radix4_ntt_butterfly (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  rnb_pkg::in_item_t                      in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output rnb_pkg::out_item_t                     out_data,
  input  logic                                   cfg_we,
  input  logic [rnb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [rnb_pkg::MODULUS_BITS-1:0]       cfg_wdata
);
  import rnb_pkg::*;

  localparam int W = MODULUS_BITS;

  function automatic logic [W-1:0] add_mod(logic [W-1:0] x, logic [W-1:0] y,
                                           logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, m}) ? W'(s - {1'b0, m}) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_mod(logic [W-1:0] x, logic [W-1:0] y,
                                           logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} - {1'b0, y} + {1'b0, m};
    return (x >= y) ? W'(x - y) : s[W-1:0];
  endfunction

  logic [W-1:0] mod_r, root_r;
  logic         en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r  <= W'(3);
      root_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS:      mod_r  <= cfg_wdata;
        CFG_QUARTER_ROOT: root_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  out_item_t out_data_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // operand reduction: lanes a, b, c, d, root, tw1, tw2, tw3
  logic [7:0][W-1:0] red_in, red_out;
  logic              red_vld, red_mode;

  assign red_in = {in_data.twiddle_three, in_data.twiddle_two, in_data.twiddle_one,
                   root_r, in_data.sample_d, in_data.sample_c, in_data.sample_b,
                   in_data.sample_a};

  rnb_reduce #(.W(W), .LANES(8), .SIDE_W(1)) u_reduce (
    .clk, .rst_n, .en,
    .in_valid (in_valid && !in_stall),
    .m        (mod_r),
    .in_val   (red_in),
    .in_side  (in_data.twiddle_mode),
    .out_valid(red_vld),
    .out_val  (red_out),
    .out_side (red_mode)
  );

  // first butterfly level
  logic              b_vld_r, b_mode_r;
  logic [W-1:0]      b_t0_r, b_t1_r, b_t2_r, b_dd_r, b_w_r;
  logic [2:0][W-1:0] b_tw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= red_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_t0_r   <= add_mod(red_out[0], red_out[2], mod_r);
      b_t2_r   <= sub_mod(red_out[0], red_out[2], mod_r);
      b_t1_r   <= add_mod(red_out[1], red_out[3], mod_r);
      b_dd_r   <= sub_mod(red_out[1], red_out[3], mod_r);
      b_w_r    <= red_out[4];
      b_tw_r   <= {red_out[7], red_out[6], red_out[5]};
      b_mode_r <= red_mode;
    end
  end

  // t3 = (b - d) * root
  localparam int S1_W = 1 + 6 * W;
  logic [0:0][W-1:0] m1_prod;
  logic [S1_W-1:0]   m1_side;
  logic              m1_vld;

  rnb_mulmod #(.W(W), .LANES(1), .SIDE_W(S1_W)) u_mul_root (
    .clk, .rst_n, .en,
    .in_valid (b_vld_r),
    .m        (mod_r),
    .in_a     (b_dd_r),
    .in_b     (b_w_r),
    .in_side  ({b_mode_r, b_tw_r, b_t0_r, b_t1_r, b_t2_r}),
    .out_valid(m1_vld),
    .out_prod (m1_prod),
    .out_side (m1_side)
  );

  // second butterfly level
  logic              d_vld_r, d_mode_r;
  logic [W-1:0]      d_p0_r, d_p1_r, d_p2_r, d_p3_r;
  logic [2:0][W-1:0] d_tw_r;
  logic [W-1:0]      s1_t0, s1_t1, s1_t2;

  assign s1_t2 = m1_side[W-1:0];
  assign s1_t1 = m1_side[2*W-1:W];
  assign s1_t0 = m1_side[3*W-1:2*W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_p0_r   <= add_mod(s1_t0, s1_t1, mod_r);
      d_p1_r   <= sub_mod(s1_t0, s1_t1, mod_r);
      d_p2_r   <= add_mod(s1_t2, m1_prod[0], mod_r);
      d_p3_r   <= sub_mod(s1_t2, m1_prod[0], mod_r);
      d_tw_r   <= m1_side[6*W-1:3*W];
      d_mode_r <= m1_side[6*W];
    end
  end

  // twiddle products: lane 0 p2*tw1, lane 1 p1*tw2, lane 2 p3*tw3
  localparam int S2_W = 1 + 4 * W;
  logic [2:0][W-1:0] m2_prod;
  logic [S2_W-1:0]   m2_side;
  logic              m2_vld;

  rnb_mulmod #(.W(W), .LANES(3), .SIDE_W(S2_W)) u_mul_twiddle (
    .clk, .rst_n, .en,
    .in_valid (d_vld_r),
    .m        (mod_r),
    .in_a     ({d_p3_r, d_p1_r, d_p2_r}),
    .in_b     (d_tw_r),
    .in_side  ({d_mode_r, d_p3_r, d_p2_r, d_p1_r, d_p0_r}),
    .out_valid(m2_vld),
    .out_prod (m2_prod),
    .out_side (m2_side)
  );

  out_item_t out_nxt;
  logic      s2_mode, small_mod;

  assign s2_mode   = m2_side[4*W];
  assign small_mod = (mod_r < W'(2));

  always_comb begin
    out_nxt.result_zero  = m2_side[W-1:0];
    out_nxt.result_one   = s2_mode ? m2_prod[0] : m2_side[3*W-1:2*W];
    out_nxt.result_two   = s2_mode ? m2_prod[1] : m2_side[2*W-1:W];
    out_nxt.result_three = s2_mode ? m2_prod[2] : m2_side[4*W-1:3*W];
    if (small_mod) begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_zero_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (mod_r >= W'(2)) |-> out_data_r.result_zero < mod_r)
    else $error("result_zero not reduced");

  a_two_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (mod_r >= W'(2)) |-> out_data_r.result_two < mod_r)
    else $error("result_two not reduced");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(b_vld_r) && $stable(d_vld_r) && $stable(m1_vld))
    else $error("pipeline moved while stalled");

endmodule
